/* rtl/rounded_rect_rasterizer_unit_defines.svh */
// Assertion macros shared by the rounded-rectangle rasterizer modules
`ifndef ROUNDED_RECT_RASTERIZER_UNIT_DEFINES_SVH
`define ROUNDED_RECT_RASTERIZER_UNIT_DEFINES_SVH

// Check a condition in the same cycle as its trigger
`define RRR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a condition in the cycle after its trigger
`define RRR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/rrr_pkg.sv */
// Shared types and constants of the rounded-rectangle rasterizer
package rrr_pkg;

	// Largest corner radius after saturation
	localparam int MAX_RADIUS = 32;
	// Bits for a clamped radius, a corner index and a square root
	localparam int RAD_W = $clog2(MAX_RADIUS + 1);
	// Bits for a squared radius
	localparam int SQ_W = 2 * RAD_W;
	// Bits for the bit position of the square-root unit
	localparam int BIT_W = (RAD_W > 1) ? $clog2(RAD_W) : 1;

	// Shape queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// Command kinds on the output stream
	typedef enum logic [1:0] {
		CMD_RECT   = 2'd0,
		CMD_HLINE  = 2'd1,
		CMD_VLINE  = 2'd2,
		CMD_CORNER = 2'd3
	} cmd_kind_t;

	// One classified shape request
	typedef struct packed {
		logic [7:0]       origin_x;
		logic [7:0]       origin_y;
		logic [7:0]       rect_width;
		logic [7:0]       rect_height;
		logic [RAD_W-1:0] radius;
		logic             fill_mode;
	} shape_t;

	// Request to the square-root unit
	typedef struct packed {
		logic            start;
		logic [SQ_W-1:0] operand;
	} sqrt_req_t;

	// Answer of the square-root unit
	typedef struct packed {
		logic             done;
		logic [RAD_W-1:0] root;
	} sqrt_rsp_t;

endpackage

/* rtl/rrr_front.sv */
// Input stage: takes request beats and clamps the corner radius
module rrr_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [39:0]     s_tdata,   // origin_x, origin_y, rect_width, rect_height, radius
	input  logic            s_tuser,   // fill_mode
	output logic            push_valid,
	input  logic            push_ready,
	output rrr_pkg::shape_t push_data
);
	import rrr_pkg::*;

	logic [7:0] in_w;
	logic [7:0] in_h;
	logic [7:0] in_r;
	logic [7:0] half_min;
	logic [7:0] r_side;
	logic [7:0] r_sat;
	shape_t     shape_s1;
	logic       valid_s1;

	assign in_w = s_tdata[23:16];
	assign in_h = s_tdata[31:24];
	assign in_r = s_tdata[39:32];

	// Clamp to half the smaller side, then saturate
	always_comb begin
		half_min = ((in_w < in_h) ? in_w : in_h) >> 1;
		r_side   = (in_r < half_min) ? in_r : half_min;
		r_sat    = (r_side > 8'(MAX_RADIUS)) ? 8'(MAX_RADIUS) : r_side;
	end

	assign s_tready = !valid_s1 || push_ready;

	// Hold one classified shape until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			shape_s1 <= '0;
		end else if (s_tvalid && s_tready) begin
			valid_s1             <= 1'b1;
			shape_s1.origin_x    <= s_tdata[7:0];
			shape_s1.origin_y    <= s_tdata[15:8];
			shape_s1.rect_width  <= in_w;
			shape_s1.rect_height <= in_h;
			shape_s1.radius      <= r_sat[RAD_W-1:0];
			shape_s1.fill_mode   <= s_tuser;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	assign push_valid = valid_s1;
	assign push_data  = shape_s1;

endmodule

/* rtl/rrr_queue.sv */
// Short shape queue that decouples the front from the command sequencer
module rrr_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  rrr_pkg::shape_t push_data,
	output logic            pop_valid,
	input  logic            pop_ready,
	output rrr_pkg::shape_t pop_data
);
	import rrr_pkg::*;

	shape_t            entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Store pushed shapes
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/rrr_isqrt.sv */
// Bit-serial integer square root, one result bit per cycle
module rrr_isqrt (
	input  logic                clk,
	input  logic                arst_n,
	input  rrr_pkg::sqrt_req_t  req,
	output rrr_pkg::sqrt_rsp_t  rsp
);
	import rrr_pkg::*;

	`include "rounded_rect_rasterizer_unit_defines.svh"

	logic             busy_q;
	logic             done_q;
	logic [BIT_W-1:0] bit_q;
	logic [SQ_W-1:0]  n_q;
	logic [RAD_W-1:0] root_q;
	logic [RAD_W-1:0] cand;
	logic [SQ_W-1:0]  cand_sq;

	// Trial root with the current bit set
	always_comb begin
		cand    = root_q | (RAD_W'(1) << bit_q);
		cand_sq = SQ_W'(cand) * SQ_W'(cand);
	end

	// Settle one bit per cycle from the top down
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			bit_q  <= '0;
			n_q    <= '0;
			root_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			bit_q  <= BIT_W'(RAD_W - 1);
			n_q    <= req.operand;
			root_q <= '0;
		end else if (busy_q) begin
			if (cand_sq <= n_q) begin
				root_q <= cand;
			end
			if (bit_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				bit_q <= bit_q - 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign rsp.done = done_q;
	assign rsp.root = root_q;

	`RRR_ASSERT_NOW(a_start_idle, req.start, !busy_q, "square root restarted while busy")
	`RRR_ASSERT_NOW(a_root_exact, done_q, ((SQ_W+1)'(root_q) * (SQ_W+1)'(root_q) <= (SQ_W+1)'(n_q)) && (((SQ_W+1)'(root_q) + 1'b1) * ((SQ_W+1)'(root_q) + 1'b1) > (SQ_W+1)'(n_q)), "square root result out of range")

endmodule

/* rtl/rrr_back.sv */
// Command sequencer: turns one shape into rectangles, lines and corner groups
module rrr_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pop_valid,
	output logic               pop_ready,
	input  rrr_pkg::shape_t    pop_data,
	output rrr_pkg::sqrt_req_t sqrt_req,
	input  rrr_pkg::sqrt_rsp_t sqrt_rsp,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [47:0]        m_tdata,   // x_left, x_right, y_top, y_bottom, span_width, span_height
	output logic [1:0]         m_tuser,   // cmd_kind
	output logic               m_tlast
);
	import rrr_pkg::*;

	`include "rounded_rect_rasterizer_unit_defines.svh"

	// Sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_HDR  = 3'd1;
	localparam logic [2:0] ST_CALC = 3'd2;
	localparam logic [2:0] ST_WAIT = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	// Index of the final leading command per mode
	localparam logic [1:0] HDR_FILL_LAST = 2'd2;
	localparam logic [1:0] HDR_LINE_LAST = 2'd3;

	logic [2:0]       state_q;
	logic [1:0]       hdr_q;
	logic [RAD_W-1:0] idx_q;
	logic [RAD_W-1:0] root_q;
	shape_t           shape_q;

	logic             out_valid_q;
	logic [47:0]      out_data_q;
	cmd_kind_t        out_kind_q;
	logic             out_last_q;

	logic             out_free;
	logic             emit;
	logic             hdr_last;
	logic             corner_last;
	logic             no_corner;
	logic [RAD_W-1:0] sq_base;
	cmd_kind_t        beat_kind;
	logic             beat_last;
	logic [7:0]       x8, y8, w8, h8, r8, r2, i8, q8;
	logic [7:0]       b_xl, b_xr, b_yt, b_yb, b_sw, b_sh;

	assign out_free  = !out_valid_q || m_tready;
	assign pop_ready = (state_q == ST_IDLE);

	// Shape operands widened to the coordinate width
	always_comb begin
		x8 = shape_q.origin_x;
		y8 = shape_q.origin_y;
		w8 = shape_q.rect_width;
		h8 = shape_q.rect_height;
		r8 = 8'(shape_q.radius);
		r2 = 8'(r8 << 1);
		i8 = 8'(idx_q);
		q8 = 8'(root_q);
	end

	// Mode-dependent end conditions
	always_comb begin
		hdr_last    = shape_q.fill_mode ? (hdr_q == HDR_FILL_LAST) : (hdr_q == HDR_LINE_LAST);
		no_corner   = shape_q.fill_mode && (shape_q.radius == '0);
		corner_last = shape_q.fill_mode ? (idx_q == shape_q.radius - RAD_W'(1))
		                                : (idx_q == shape_q.radius);
		sq_base     = shape_q.fill_mode ? (shape_q.radius - RAD_W'(1) - idx_q) : idx_q;
	end

	// Start the root of r*r minus the offset squared
	always_comb begin
		sqrt_req.start   = (state_q == ST_CALC);
		sqrt_req.operand = SQ_W'(shape_q.radius) * SQ_W'(shape_q.radius)
		                 - SQ_W'(sq_base) * SQ_W'(sq_base);
	end

	// Build the next output beat
	always_comb begin
		emit      = 1'b0;
		beat_kind = CMD_RECT;
		beat_last = 1'b0;
		b_xl      = '0;
		b_xr      = '0;
		b_yt      = '0;
		b_yb      = '0;
		b_sw      = '0;
		b_sh      = '0;
		unique case (state_q)
			ST_HDR: begin
				emit      = out_free;
				beat_last = hdr_last && no_corner;
				if (shape_q.fill_mode) begin
					beat_kind = CMD_RECT;
					unique case (hdr_q)
						2'd0: begin
							b_xl = x8 + r8;
							b_yt = y8;
							b_sw = w8 - r2;
							b_sh = h8;
						end
						2'd1: begin
							b_xl = x8;
							b_yt = y8 + r8;
							b_sw = r8;
							b_sh = h8 - r2;
						end
						default: begin
							b_xl = x8 + w8 - r8;
							b_yt = y8 + r8;
							b_sw = r8;
							b_sh = h8 - r2;
						end
					endcase
				end else begin
					unique case (hdr_q)
						2'd0: begin
							beat_kind = CMD_HLINE;
							b_xl      = x8 + r8;
							b_yt      = y8;
							b_sw      = w8 - r2;
						end
						2'd1: begin
							beat_kind = CMD_HLINE;
							b_xl      = x8 + r8;
							b_yt      = y8 + h8 - 8'd1;
							b_sw      = w8 - r2;
						end
						2'd2: begin
							beat_kind = CMD_VLINE;
							b_xl      = x8;
							b_yt      = y8 + r8;
							b_sh      = h8 - r2;
						end
						default: begin
							beat_kind = CMD_VLINE;
							b_xl      = x8 + w8 - 8'd1;
							b_yt      = y8 + r8;
							b_sh      = h8 - r2;
						end
					endcase
				end
			end
			ST_EMIT: begin
				emit      = out_free;
				beat_kind = CMD_CORNER;
				beat_last = corner_last;
				if (shape_q.fill_mode) begin
					// Mirrored spans of the current row
					b_xl = x8 + r8 - q8;
					b_xr = x8 + w8 - r8;
					b_yt = y8 + i8;
					b_yb = y8 + h8 - 8'd1 - i8;
					b_sw = q8;
				end else begin
					// Mirrored pixels of the current column
					b_xl = x8 + r8 - i8;
					b_xr = x8 + w8 - r8 - 8'd1 + i8;
					b_yt = y8 + r8 - q8;
					b_yb = y8 + h8 - r8 - 8'd1 + q8;
					b_sw = 8'd1;
				end
			end
			default: begin
			end
		endcase
	end

	// Step through leading commands, then one corner group per row or column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			hdr_q   <= '0;
			idx_q   <= '0;
			root_q  <= '0;
			shape_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						shape_q <= pop_data;
						hdr_q   <= '0;
						state_q <= ST_HDR;
					end
				end
				ST_HDR: begin
					if (out_free) begin
						if (!hdr_last) begin
							hdr_q <= hdr_q + 1'b1;
						end else if (no_corner) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= '0;
							state_q <= ST_CALC;
						end
					end
				end
				ST_CALC: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (sqrt_rsp.done) begin
						root_q  <= sqrt_rsp.root;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						if (corner_last) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_CALC;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register: load a beat when free, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			out_kind_q  <= CMD_RECT;
			out_last_q  <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
			out_data_q  <= {b_sh, b_sw, b_yb, b_yt, b_xr, b_xl};
			out_kind_q  <= beat_kind;
			out_last_q  <= beat_last;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

	`RRR_ASSERT_NOW(a_radius_clamped, state_q != ST_IDLE, (shape_q.radius <= RAD_W'(MAX_RADIUS)) && (r8 <= (w8 >> 1)) && (r8 <= (h8 >> 1)), "radius not clamped")
	`RRR_ASSERT_NOW(a_root_when_waiting, sqrt_rsp.done, state_q == ST_WAIT, "square root answered outside wait")
	`RRR_ASSERT_NOW(a_corner_index, state_q == ST_EMIT, idx_q <= shape_q.radius, "corner index beyond radius")
	`RRR_ASSERT_NEXT(a_last_ends_shape, emit && beat_last, state_q == ST_IDLE, "sequencer busy after final beat")

endmodule

/* rtl/rounded_rect_rasterizer_unit.sv */
// Top level of the rounded-rectangle rasterizer
//
// Channel  Dir  Handshake            Payload
// s_*      in   s_tvalid / s_tready  tdata: x, y, width, height, radius; tuser: fill flag
// m_*      out  m_tvalid / m_tready  tdata: corner/span fields; tuser: command kind; tlast
//
// A filled shape with clamped radius r gives three rectangles and r corner
// groups; an outline gives four lines and r + 1 corner groups.
// Each corner group computes r*r - d*d, then runs it through the bit-serial
// square-root unit at one root bit per cycle, then captures the root and
// emits the beat. arst_n clears the control state; no clearing pass.
// A queue of two shapes lets requests land while the sequencer is stalled
// by m_tready.
module rounded_rect_rasterizer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // origin_x, origin_y, rect_width, rect_height, radius
	input  logic        s_tuser,   // fill_mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // x_left, x_right, y_top, y_bottom, span_width, span_height
	output logic [1:0]  m_tuser,   // cmd_kind
	output logic        m_tlast
);
	import rrr_pkg::*;

	logic      push_valid;
	logic      push_ready;
	shape_t    push_data;
	logic      pop_valid;
	logic      pop_ready;
	shape_t    pop_data;
	sqrt_req_t sqrt_req;
	sqrt_rsp_t sqrt_rsp;

	// Accept and classify requests
	rrr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	// Decouple front and sequencer
	rrr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// Corner span lengths
	rrr_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sqrt_req),
		.rsp    (sqrt_rsp)
	);

	// Generate the command stream
	rrr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.sqrt_req  (sqrt_req),
		.sqrt_rsp  (sqrt_rsp),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the rounded-rectangle rasterizer top level
module tb_top;
	import rrr_pkg::*;

	// Expected command beat
	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] x_left;
		logic [7:0] x_right;
		logic [7:0] y_top;
		logic [7:0] y_bottom;
		logic [7:0] span_width;
		logic [7:0] span_height;
		logic       is_last;
	} draw_cmd_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;   // origin_x, origin_y, rect_width, rect_height, radius
	logic        s_tuser;   // fill_mode
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;   // x_left, x_right, y_top, y_bottom, span_width, span_height
	logic [1:0]  m_tuser;   // cmd_kind
	logic        m_tlast;

	draw_cmd_t pending_cmds[$];
	int        mismatch_count = 0;
	int        shapes_sent = 0;
	int        filled_shapes = 0;
	int        beats_checked = 0;
	bit        idle_on = 1'b1;

	rounded_rect_rasterizer_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// 20-unit clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Floor of the square root, by plain search
	function automatic int root_floor(input int n);
		int s;
		s = 0;
		while ((s + 1) * (s + 1) <= n)
			s++;
		return s;
	endfunction

	// Queue one expected beat, truncating every field to the bus width
	function automatic void add_cmd(input cmd_kind_t kind, input int xl, input int xr,
			input int yt, input int yb, input int sw, input int sh, input bit is_last);
		draw_cmd_t c;
		c.kind        = kind;
		c.x_left      = xl[7:0];
		c.x_right     = xr[7:0];
		c.y_top       = yt[7:0];
		c.y_bottom    = yb[7:0];
		c.span_width  = sw[7:0];
		c.span_height = sh[7:0];
		c.is_last     = is_last;
		pending_cmds.push_back(c);
	endfunction

	// Work out the command run of one shape
	function automatic void predict_shape(input logic [7:0] ox, input logic [7:0] oy,
			input logic [7:0] rw, input logic [7:0] rh, input logic [7:0] rad,
			input logic fill);
		int x, y, w, h, r, total, i, d, len, dy;
		x = int'(ox);
		y = int'(oy);
		w = int'(rw);
		h = int'(rh);
		r = int'(rad);
		// Clamp to half the smaller side, then saturate
		if (r > w / 2 || r > h / 2)
			r = ((w < h) ? w : h) / 2;
		if (r > MAX_RADIUS)
			r = MAX_RADIUS;

		if (fill) begin
			total = 3 + r;
			add_cmd(CMD_RECT, x + r, 0, y, 0, w - 2 * r, h, total == 1);
			add_cmd(CMD_RECT, x, 0, y + r, 0, r, h - 2 * r, total == 2);
			add_cmd(CMD_RECT, x + w - r, 0, y + r, 0, r, h - 2 * r, total == 3);
			// One mirrored span group per corner row
			for (i = 0; i < r; i++) begin
				d = r - 1 - i;
				len = root_floor(r * r - d * d);
				add_cmd(CMD_CORNER, x + r - len, x + w - r, y + i, y + h - 1 - i,
					len, 0, i == r - 1);
			end
		end else begin
			add_cmd(CMD_HLINE, x + r, 0, y, 0, w - 2 * r, 0, 1'b0);
			add_cmd(CMD_HLINE, x + r, 0, y + h - 1, 0, w - 2 * r, 0, 1'b0);
			add_cmd(CMD_VLINE, x, 0, y + r, 0, 0, h - 2 * r, 1'b0);
			add_cmd(CMD_VLINE, x + w - 1, 0, y + r, 0, 0, h - 2 * r, 1'b0);
			// One mirrored pixel group per corner column, including the zero radius case
			for (i = 0; i <= r; i++) begin
				dy = root_floor(r * r - i * i);
				add_cmd(CMD_CORNER, x + r - i, x + w - r - 1 + i, y + r - dy,
					y + h - r - 1 + dy, 1, 0, i == r);
			end
		end
	endfunction

	// Send one shape request; called and returns just after a falling edge
	task automatic send_shape(input logic [7:0] ox, input logic [7:0] oy,
			input logic [7:0] rw, input logic [7:0] rh, input logic [7:0] rad,
			input logic fill);
		int gap;
		gap = idle_on ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {rad, rh, rw, oy, ox};
		s_tuser  <= fill;
		do
			@(posedge clk);
		while (!s_tready);
		predict_shape(ox, oy, rw, rh, rad, fill);
		shapes_sent++;
		if (fill)
			filled_shapes++;
		@(negedge clk);
	endtask

	// Sizes and radii of zero, and one-pixel sides
	task automatic test_degenerate_sizes();
		send_shape(8'd10, 8'd20, 8'd0, 8'd0, 8'd0, 1'b1);
		send_shape(8'd10, 8'd20, 8'd0, 8'd0, 8'd255, 1'b0);
		send_shape(8'd0, 8'd0, 8'd1, 8'd255, 8'd7, 1'b1);
		send_shape(8'd0, 8'd0, 8'd255, 8'd1, 8'd7, 1'b0);
		send_shape(8'd5, 8'd5, 8'd40, 8'd30, 8'd0, 1'b1);
		send_shape(8'd5, 8'd5, 8'd40, 8'd30, 8'd0, 1'b0);
	endtask

	// Radius at, just over and far over its limits
	task automatic test_radius_clamping();
		send_shape(8'd100, 8'd100, 8'd2, 8'd2, 8'd1, 1'b1);
		send_shape(8'd100, 8'd100, 8'd3, 8'd3, 8'd1, 1'b0);
		send_shape(8'd0, 8'd0, 8'd20, 8'd30, 8'd10, 1'b1);
		send_shape(8'd0, 8'd0, 8'd50, 8'd21, 8'd30, 1'b0);
		send_shape(8'd0, 8'd0, 8'd64, 8'd64, 8'd32, 1'b1);
		send_shape(8'd0, 8'd0, 8'd66, 8'd66, 8'd33, 1'b0);
		send_shape(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
		send_shape(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
	endtask

	// Shapes that run off the right or bottom and wrap round
	task automatic test_coordinate_wrap();
		send_shape(8'd250, 8'd240, 8'd20, 8'd40, 8'd8, 1'b1);
		send_shape(8'd250, 8'd240, 8'd20, 8'd40, 8'd8, 1'b0);
		send_shape(8'd200, 8'd200, 8'd255, 8'd200, 8'd20, 1'b1);
		send_shape(8'd255, 8'd0, 8'd128, 8'd128, 8'd255, 1'b0);
	endtask

	// Random shapes: mostly moderate radii, some tiny shapes, some full-range radii
	task automatic test_random_shapes(input int count);
		int          n, mix;
		logic [7:0]  rw, rh, rad;
		for (n = 0; n < count; n++) begin
			mix = $urandom_range(0, 9);
			if (mix < 6) begin
				rw  = 8'($urandom_range(0, 255));
				rh  = 8'($urandom_range(0, 255));
				rad = 8'($urandom_range(0, 40));
			end else if (mix < 8) begin
				rw  = 8'($urandom_range(0, 20));
				rh  = 8'($urandom_range(0, 20));
				rad = 8'($urandom_range(0, 15));
			end else begin
				rw  = 8'($urandom_range(0, 255));
				rh  = 8'($urandom_range(0, 255));
				rad = 8'($urandom_range(0, 255));
			end
			send_shape(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), rw, rh, rad,
				1'($urandom_range(0, 1)));
		end
	endtask

	// Random shapes with both sides at full rate
	task automatic test_back_to_back(input int count);
		idle_on = 1'b0;
		test_random_shapes(count);
		idle_on = 1'b1;
	endtask

	// Reset and main sequence
	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_degenerate_sizes();
		test_radius_clamping();
		test_coordinate_wrap();
		test_random_shapes(82);
		test_back_to_back(30);
		s_tvalid <= 1'b0;

		// Drain, then give stray beats time to show
		while (pending_cmds.size() != 0)
			@(posedge clk);
		repeat (320) @(posedge clk);

		$display("Sent %0d shapes (%0d filled, %0d outlines) including clamp and wrap cases,",
			shapes_sent, filled_shapes, shapes_sent - filled_shapes);
		$display("and compared %0d command beats field by field.", beats_checked);
		if (mismatch_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Output back-pressure: hold tready low for a random stall before each beat
	initial begin
		int stall;
		m_tready = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			stall = idle_on ? $urandom_range(0, 3) : 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do
				@(posedge clk);
			while (!m_tvalid);
			@(negedge clk);
		end
	end

	// Compare each accepted beat with the oldest expected command
	always @(posedge clk) begin
		draw_cmd_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_cmds.size() == 0) begin
				$error("unexpected command beat: kind %0d tdata %h", m_tuser, m_tdata);
				mismatch_count++;
			end else begin
				want = pending_cmds.pop_front();
				beats_checked++;
				if (m_tuser !== want.kind) begin
					$error("cmd_kind: expected %0d, got %0d", want.kind, m_tuser);
					mismatch_count++;
				end
				if (m_tdata[7:0] !== want.x_left) begin
					$error("x_left: expected %0d, got %0d", want.x_left, m_tdata[7:0]);
					mismatch_count++;
				end
				if (m_tdata[15:8] !== want.x_right) begin
					$error("x_right: expected %0d, got %0d", want.x_right, m_tdata[15:8]);
					mismatch_count++;
				end
				if (m_tdata[23:16] !== want.y_top) begin
					$error("y_top: expected %0d, got %0d", want.y_top, m_tdata[23:16]);
					mismatch_count++;
				end
				if (m_tdata[31:24] !== want.y_bottom) begin
					$error("y_bottom: expected %0d, got %0d", want.y_bottom, m_tdata[31:24]);
					mismatch_count++;
				end
				if (m_tdata[39:32] !== want.span_width) begin
					$error("span_width: expected %0d, got %0d", want.span_width,
						m_tdata[39:32]);
					mismatch_count++;
				end
				if (m_tdata[47:40] !== want.span_height) begin
					$error("span_height: expected %0d, got %0d", want.span_height,
						m_tdata[47:40]);
					mismatch_count++;
				end
				if (m_tlast !== want.is_last) begin
					$error("last: expected %0d, got %0d", want.is_last, m_tlast);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog
	initial begin
		#10_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
